[rtl/lrd_pkg.sv]
// ----------------------------------------------------------------------------
// Log record deframer package
// Shared phase and result codes, header field sizes, the result record type
// and the negative-timestamp test.
// ----------------------------------------------------------------------------
package lrd_pkg;

   // Header field sizes in bytes.
   localparam logic [3:0] STAMP_BYTES  = 4'd8;
   localparam logic [3:0] IDENT_BYTES  = 4'd2;
   localparam logic [3:0] LENGTH_BYTES = 4'd4;

   // Configuration register indexes.
   localparam logic [7:0] CSR_START_BYTE = 8'd0;
   localparam logic [7:0] CSR_BIG_ENDIAN = 8'd1;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_STAMP   = 3'd1,
      PH_IDENT   = 3'd2,
      PH_LENGTH  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CHECK   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD   = 2'd0,
      KIND_PACKET_OK = 2'd1,
      KIND_SUM_ERROR = 2'd2,
      KIND_TS_ERROR  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic [15:0] packet_id;
      logic [63:0] timestamp_bits;
      logic [31:0] payload_len;
      logic        last;
   } result_type;

   // True for a negative double: sign set, not minus zero, not a NaN.
   // Minus infinity counts as negative.
   function automatic logic stamp_negative(input logic [63:0] bits);
      logic mag_nonzero;
      logic is_nan;
      begin
         mag_nonzero = |bits[62:0];
         is_nan      = (&bits[62:52]) && (|bits[51:0]);
         return bits[63] && mag_nonzero && !is_nan;
      end
   endfunction

endpackage

[rtl/log_record_deframer.sv]
// ----------------------------------------------------------------------------
// Log record deframer
// Splits a raw log byte stream into records and reports payload bytes and
// record status together with the decoded header fields.
// ----------------------------------------------------------------------------
// Usage: raw bytes arrive on the req_ channel, one byte per transfer. The
// block hunts for csr start_byte, then reads an 8-byte timestamp, a 2-byte id
// and a 4-byte length in the byte order set by csr big_endian. Each payload
// byte leaves on the rsp_ channel as a kind 0 transfer carrying the header
// fields; the checksum byte that follows gives packet ok or checksum error.
// A negative timestamp gives a timestamp error at once and the hunt resumes.
// Other header bytes and hunted bytes produce no rsp_ transfer.
// The block takes one byte per cycle while the result buffer is not full:
// the byte is captured in an input register, the parser updates its state
// in the next cycle, and any result lands in a two-entry result buffer,
// which presents it on rsp_ and hands it over at an edge with rsp_stall low.
// When the receiver stalls, the buffer absorbs the result in flight and
// req_stall rises once the buffer is full; it is driven from registers only.
// Reset (synchronous, active high) clears the registers to start_byte zero
// and little-endian order, empties the pipeline and returns to hunting.
// Configuration writes are always ready and should be made while idle.
// ----------------------------------------------------------------------------
module log_record_deframer import lrd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Byte input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_packet_id,
   output logic [63:0] rsp_timestamp_bits,
   output logic [31:0] rsp_payload_len,
   output logic        rsp_last,
   // Configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [7:0]  start_byte_ff;
   logic        big_endian_ff;
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        step;
   logic        req_take;
   logic        res_valid;
   result_type  res_data;
   logic        buf_full;
   result_type  rsp_data;

   // Configuration registers; writes to an unknown index are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= 8'd0;
         big_endian_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_BYTE: start_byte_ff <= csr_wdata;
            CSR_BIG_ENDIAN: big_endian_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The held byte moves into the parser whenever the result buffer has
   // room, so the input register frees up in the same cycle.
   assign step      = in_valid_ff && !buf_full;
   assign req_stall = in_valid_ff && buf_full;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_take || (in_valid_ff && !step);
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_byte_in;
      end
   end

   lrd_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .byte_in    (in_byte_ff),
      .start_byte (start_byte_ff),
      .big_endian (big_endian_ff),
      .res_valid  (res_valid),
      .res_data   (res_data)
   );

   lrd_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (step && res_valid),
      .wr_data  (res_data),
      .rd_en    (!rsp_stall),
      .full     (buf_full),
      .rd_valid (rsp_valid),
      .rd_data  (rsp_data)
   );

   assign rsp_kind           = rsp_data.kind;
   assign rsp_payload_byte   = rsp_data.payload_byte;
   assign rsp_packet_id      = rsp_data.packet_id;
   assign rsp_timestamp_bits = rsp_data.timestamp_bits;
   assign rsp_payload_len    = rsp_data.payload_len;
   assign rsp_last           = rsp_data.last;

endmodule

[rtl/lrd_parse.sv]
// ----------------------------------------------------------------------------
// Log record deframer field parser
// Holds the record state machine and header registers, and turns one
// registered byte into at most one result per step.
// ----------------------------------------------------------------------------
module lrd_parse import lrd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  byte_in,
   input  logic [7:0]  start_byte,
   input  logic        big_endian,
   output logic        res_valid,
   output result_type  res_data
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [63:0] stamp_ff, stamp_in;
   logic [15:0] ident_ff, ident_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] remain_ff, remain_in;
   logic [7:0]  sum_ff, sum_in;
   logic [3:0]  count_inc;
   logic [31:0] remain_dec;

   assign count_inc  = count_ff + 4'd1;
   assign remain_dec = remain_ff - 32'd1;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      stamp_in  = stamp_ff;
      ident_in  = ident_ff;
      length_in = length_ff;
      remain_in = remain_ff;
      sum_in    = sum_ff;
      res_valid = 1'b0;
      res_data  = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, packet_id: ident_ff,
                    timestamp_bits: stamp_ff, payload_len: length_ff, last: 1'b0};

      unique case (phase_ff)
         PH_STAMP: begin
            stamp_in = big_endian ? {stamp_ff[55:0], byte_in}
                                  : {byte_in, stamp_ff[63:8]};
            count_in = count_inc;
            if (count_inc >= STAMP_BYTES) begin
               count_in = 4'd0;
               if (stamp_negative(stamp_in)) begin
                  phase_in  = PH_HUNT;
                  res_valid = 1'b1;
                  res_data  = '{kind: KIND_TS_ERROR, payload_byte: 8'd0,
                                packet_id: 16'd0, timestamp_bits: stamp_in,
                                payload_len: 32'd0, last: 1'b1};
               end else begin
                  phase_in = PH_IDENT;
               end
            end
         end
         PH_IDENT: begin
            ident_in = big_endian ? {ident_ff[7:0], byte_in}
                                  : {byte_in, ident_ff[15:8]};
            count_in = count_inc;
            if (count_inc >= IDENT_BYTES) begin
               count_in = 4'd0;
               phase_in = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            length_in = big_endian ? {length_ff[23:0], byte_in}
                                   : {byte_in, length_ff[31:8]};
            count_in = count_inc;
            if (count_inc >= LENGTH_BYTES) begin
               count_in  = 4'd0;
               remain_in = length_in;
               sum_in    = 8'd0;
               phase_in  = (length_in == 32'd0) ? PH_CHECK : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            sum_in    = sum_ff + byte_in;
            remain_in = remain_dec;
            if (remain_dec == 32'd0) begin
               phase_in = PH_CHECK;
            end
            res_valid = 1'b1;
            res_data.payload_byte = byte_in;
         end
         PH_CHECK: begin
            phase_in      = PH_HUNT;
            res_valid     = 1'b1;
            res_data.kind = (byte_in == sum_ff) ? KIND_PACKET_OK : KIND_SUM_ERROR;
            res_data.last = 1'b1;
         end
         default: begin
            // Hunting; an unknown phase is treated the same way.
            phase_in = PH_HUNT;
            if (byte_in == start_byte) begin
               phase_in  = PH_STAMP;
               count_in  = 4'd0;
               stamp_in  = 64'd0;
               ident_in  = 16'd0;
               length_in = 32'd0;
               remain_in = 32'd0;
               sum_in    = 8'd0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         count_ff  <= 4'd0;
         stamp_ff  <= 64'd0;
         ident_ff  <= 16'd0;
         length_ff <= 32'd0;
         remain_ff <= 32'd0;
         sum_ff    <= 8'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         stamp_ff  <= stamp_in;
         ident_ff  <= ident_in;
         length_ff <= length_in;
         remain_ff <= remain_in;
         sum_ff    <= sum_in;
      end
   end

endmodule

[rtl/lrd_rsp_fifo.sv]
// ----------------------------------------------------------------------------
// Log record deframer result buffer
// Two-entry result register that lets the parser keep stepping after the
// receiver raises stall, until both entries are filled.
// ----------------------------------------------------------------------------
module lrd_rsp_fifo import lrd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  result_type  wr_data,
   input  logic        rd_en,
   output logic        full,
   output logic        rd_valid,
   output result_type  rd_data
);

   result_type  mem_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        do_rd;

   assign full     = (count_ff == 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_rd    = rd_en && rd_valid;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_rd) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, wr_en} - {1'b0, do_rd};
      end
   end

endmodule

[tb/sv/tb_log_record_deframer.sv]
// ----------------------------------------------------------------------------
// Log record deframer testbench
// Drives a raw byte stream into the deframer and checks every result against
// a cycle-free parser model kept alongside. It covers framed records in both
// byte orders, odd timestamps, broken framing, a byte order switched part way
// through a field, a long receiver hold-off and a header with an all-ones
// length. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_log_record_deframer;
   import lrd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The watchdog gives up after this many cycles without any transfer. The
   // longest correct pause is the receiver hold-off plus a long sender gap,
   // well short of this limit.
   localparam int unsigned STALL_LIMIT  = 2000;
   // Length of the deliberate receiver hold-off, in cycles.
   localparam int unsigned HOLD_CYCLES  = 150;
   // A result leaves through the input register and the result buffer; a byte
   // that gives no result is through the pipeline well within this many cycles.
   localparam int unsigned SETTLE_CYCLES = 6;

   // ------------------------------------------------------------------------
   // Clock, reset and the block's ports. Every input starts at a known value.
   // ------------------------------------------------------------------------
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic [15:0] rsp_packet_id;
   logic [63:0] rsp_timestamp_bits;
   logic [31:0] rsp_payload_len;
   logic        rsp_last;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index   = 8'h00;
   logic [7:0]  csr_wdata   = 8'h00;

   initial begin : clock_gen
      forever #1 clock = ~clock;
   end

   log_record_deframer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_in        (req_byte_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_packet_id      (rsp_packet_id),
      .rsp_timestamp_bits (rsp_timestamp_bits),
      .rsp_payload_len    (rsp_payload_len),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Parser model. It holds its own copy of the registers and of the field
   // state machine, and is stepped once for every byte transfer the block
   // accepts. Any result it produces joins the back of predicted_rsp.
   // ------------------------------------------------------------------------
   logic [7:0]  cfg_start = 8'h00;
   logic        cfg_big   = 1'b0;

   phase_type   ps_phase     = PH_HUNT;
   logic [3:0]  ps_count     = 4'd0;
   logic [63:0] ps_stamp     = '0;
   logic [15:0] ps_ident     = '0;
   logic [31:0] ps_length    = '0;
   logic [31:0] ps_remaining = '0;
   logic [7:0]  ps_sum       = 8'h00;

   result_type  predicted_rsp[$];
   int unsigned fault_count    = 0;
   int unsigned bytes_accepted = 0;

   // Shared idling controls: calm suppresses all idling on both sides, and
   // hold_requested asks the receiver for one long hold-off.
   bit calm           = 1'b0;
   bit hold_requested = 1'b0;

   // A timestamp is rejected when its pattern is a negative double. Minus
   // zero is not negative, minus infinity is, and a NaN never is, whatever
   // its sign bit says.
   function automatic bit below_zero(input logic [63:0] bits);
      bit exponent_full;
      bit fraction_set;
      exponent_full = (bits[62:52] == 11'h7FF);
      fraction_set  = (bits[51:0] != '0);
      return bits[63] && (bits[62:0] != '0) && !(exponent_full && fraction_set);
   endfunction

   task automatic parse_byte(input logic [7:0] b);
      result_type r;
      bit         produced;
      r        = '0;
      produced = 1'b0;
      case (ps_phase)
         PH_STAMP: begin
            // Each byte is shifted in by the byte order in force right now,
            // so a switch of order part way through gives a mixed pattern.
            ps_stamp = cfg_big ? {ps_stamp[55:0], b} : {b, ps_stamp[63:8]};
            ps_count = ps_count + 4'd1;
            if (ps_count >= STAMP_BYTES) begin
               ps_count = 4'd0;
               if (below_zero(ps_stamp)) begin
                  // The record is abandoned at once and the hunt resumes.
                  ps_phase         = PH_HUNT;
                  r.kind           = KIND_TS_ERROR;
                  r.timestamp_bits = ps_stamp;
                  r.last           = 1'b1;
                  produced         = 1'b1;
               end else begin
                  ps_phase = PH_IDENT;
               end
            end
         end
         PH_IDENT: begin
            ps_ident = cfg_big ? {ps_ident[7:0], b} : {b, ps_ident[15:8]};
            ps_count = ps_count + 4'd1;
            if (ps_count >= IDENT_BYTES) begin
               ps_count = 4'd0;
               ps_phase = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            ps_length = cfg_big ? {ps_length[23:0], b} : {b, ps_length[31:8]};
            ps_count  = ps_count + 4'd1;
            if (ps_count >= LENGTH_BYTES) begin
               ps_count     = 4'd0;
               ps_remaining = ps_length;
               ps_sum       = 8'h00;
               // With no payload the very next byte is the checksum, and it
               // is compared with an empty sum.
               ps_phase     = (ps_length == 32'd0) ? PH_CHECK : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            ps_sum       = ps_sum + b;
            ps_remaining = ps_remaining - 32'd1;
            if (ps_remaining == 32'd0) begin
               ps_phase = PH_CHECK;
            end
            r.kind           = KIND_PAYLOAD;
            r.payload_byte   = b;
            r.packet_id      = ps_ident;
            r.timestamp_bits = ps_stamp;
            r.payload_len    = ps_length;
            produced         = 1'b1;
         end
         PH_CHECK: begin
            ps_phase         = PH_HUNT;
            r.kind           = (b == ps_sum) ? KIND_PACKET_OK : KIND_SUM_ERROR;
            r.packet_id      = ps_ident;
            r.timestamp_bits = ps_stamp;
            r.payload_len    = ps_length;
            r.last           = 1'b1;
            produced         = 1'b1;
         end
         default: begin
            // Hunting. The start byte is only looked for between records;
            // inside a record it is ordinary data.
            ps_phase = PH_HUNT;
            if (b == cfg_start) begin
               ps_phase     = PH_STAMP;
               ps_count     = 4'd0;
               ps_stamp     = '0;
               ps_ident     = '0;
               ps_length    = '0;
               ps_remaining = '0;
               ps_sum       = 8'h00;
            end
         end
      endcase
      if (produced) begin
         predicted_rsp.push_back(r);
      end
   endtask

   // ------------------------------------------------------------------------
   // Idle lengths: mostly none, often a few cycles, now and then a long one.
   // ------------------------------------------------------------------------
   function automatic int unsigned pause_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) begin
         return 0;
      end
      if (roll < 88) begin
         return $urandom_range(1, 3);
      end
      if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------------
   // Byte sender. The byte is presented at a rising edge and held until the
   // block takes it. When no gap follows, valid simply stays high for the
   // next byte, so it is never lowered and raised within one time step.
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      req_valid   <= 1'b1;
      req_byte_in <= b;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      parse_byte(b);
      bytes_accepted++;
      gap = pause_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sends the low count bytes of a header field in the current byte order.
   task automatic send_field(input logic [63:0] value, input int unsigned count);
      logic [7:0] b;
      for (int unsigned i = 0; i < count; i++) begin
         b = cfg_big ? value[8*(count-1-i) +: 8] : value[8*i +: 8];
         send_byte(b);
      end
   endtask

   // Id, length, payload and checksum of a record whose timestamp is already
   // in. Fewer body bytes than the length leaves the record open. The correct
   // checksum is taken from the sum the model has built up.
   task automatic finish_record(input logic [15:0] id, input logic [31:0] len,
                                input int unsigned body, input bit good);
      logic [7:0] b;
      logic [7:0] spoil;
      send_field(64'(id), 2);
      send_field(64'(len), 4);
      for (int unsigned i = 0; i < body; i++) begin
         b = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 5) == 0) begin
            b = cfg_start;
         end
         send_byte(b);
      end
      if (body == len) begin
         spoil = 8'($urandom_range(1, 255));
         send_byte(good ? ps_sum : ps_sum + spoil);
      end
   endtask

   task automatic send_record(input logic [63:0] ts, input logic [15:0] id,
                              input logic [31:0] len, input int unsigned body,
                              input bit good);
      send_byte(cfg_start);
      send_field(ts, 8);
      // A negative timestamp sends the block back to hunting; the rest of
      // the record is dropped.
      if (ps_phase != PH_HUNT) begin
         finish_record(id, len, body, good);
      end
   endtask

   // A record cut short inside its timestamp or id. The next start byte then
   // lands in the header as data, and zero bytes bring the block round to a
   // zero-length record and back to hunting.
   task automatic send_broken_record();
      int unsigned cut;
      cut = $urandom_range(0, 9);
      send_byte(cfg_start);
      repeat (cut) send_byte(8'($urandom_range(0, 255)));
      if (ps_phase != PH_HUNT) begin
         send_byte(cfg_start);
      end
      while (ps_phase != PH_HUNT) begin
         send_byte(8'h00);
      end
   endtask

   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == cfg_start);
      return b;
   endfunction

   function automatic logic [63:0] pick_stamp();
      logic [63:0] ts;
      ts = {$urandom, $urandom};
      case ($urandom_range(0, 11))
         0: ts = 64'hFFF0_0000_0000_0000;              // minus infinity
         1: ts = 64'h8000_0000_0000_0000;              // minus zero
         2: ts[63:52] = 12'hFFF;                       // NaN with sign, mostly
         3: ts = 64'h8000_0000_0000_0001;              // smallest negative
         4: ts = 64'hFFFF_FFFF_FFFF_FFFF;              // all ones, a NaN
         5: ts[63] = 1'b1;                             // some negative value
         6: ts = ts;                                   // anything at all
         default: ts[63] = 1'b0;                       // positive
      endcase
      return ts;
   endfunction

   // ------------------------------------------------------------------------
   // Configuration writes. Each write holds valid until ready is seen; valid
   // stays up across back-to-back writes and is lowered by the caller.
   // ------------------------------------------------------------------------
   task automatic write_csr(input logic [7:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do begin
         @(posedge clock);
      end while (csr_ready !== 1'b1);
      // Unknown indexes are ignored and spare data bits dropped.
      if (idx == CSR_START_BYTE) begin
         cfg_start = value;
      end else if (idx == CSR_BIG_ENDIAN) begin
         cfg_big = value[0];
      end
   endtask

   // Waits for every predicted result, then lets any byte that gives no
   // result clear the pipeline.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (predicted_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_registers(input logic [7:0] start_value,
                                input logic [7:0] order_value);
      drain_block();
      write_csr(8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
      write_csr(CSR_START_BYTE, start_value);
      write_csr(CSR_BIG_ENDIAN, order_value);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Straight after reset: start byte zero, little-endian. An empty record
   // with the largest id, then a record whose timestamp is minus infinity.
   task automatic test_first_records();
      send_record(64'h3FF0_0000_0000_0000, 16'hFFFF, 32'd0, 0, 1'b1);
      send_record(64'hFFF0_0000_0000_0000, 16'h0000, 32'd0, 0, 1'b1);
      drain_block();
   endtask

   // Half the timestamp goes in little-endian, then the order is switched
   // to big-endian while the block waits for the rest of the field.
   task automatic test_order_switch_mid_field();
      set_registers(8'h5A, 8'h00);
      send_byte(8'h5A);
      send_byte(8'hC3);
      send_byte(8'h81);
      send_byte(8'hFF);
      send_byte(8'h96);
      drain_block();
      write_csr(CSR_BIG_ENDIAN, 8'h01);
      csr_valid <= 1'b0;
      send_byte(8'h3C);
      send_byte(8'h00);
      send_byte(8'h7E);
      send_byte(8'h42);
      if (ps_phase != PH_HUNT) begin
         finish_record(16'hA55A, 32'd2, 2, 1'b1);
      end
      drain_block();
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering payload bytes, so the result buffer fills and the block stalls
   // its input.
   task automatic test_receiver_hold_off();
      set_registers(8'hC7, 8'h00);
      calm           = 1'b1;
      hold_requested = 1'b1;
      send_record(64'h4000_0000_0000_0000, 16'h1234, 32'd40, 40, 1'b1);
      drain_block();
      calm = 1'b0;
   endtask

   // Mostly well-formed records with random content, some noise between
   // them, and a share of broken framing. Each phase runs with its own
   // register settings, the extremes first.
   task automatic test_random_traffic();
      logic [7:0]  start_value;
      logic [7:0]  order_value;
      logic [31:0] len;
      int unsigned stop_at;
      for (int p = 0; p < 7; p++) begin
         start_value    = 8'($urandom_range(0, 255));
         order_value    = 8'($urandom_range(0, 255));
         order_value[0] = p[0];
         if (p == 0) begin
            start_value = 8'h00;
            order_value = 8'h00;
         end else if (p == 1) begin
            start_value = 8'hFF;
            order_value = 8'hFF;
         end
         set_registers(start_value, order_value);
         stop_at = bytes_accepted + 190;
         while (bytes_accepted < stop_at) begin
            if ($urandom_range(0, 3) == 0) begin
               calm = !calm;
            end
            repeat ($urandom_range(0, 2)) send_byte(noise_byte());
            if ($urandom_range(0, 99) < 12) begin
               send_broken_record();
            end else begin
               len = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 12);
               send_record(pick_stamp(), 16'($urandom_range(0, 65535)), len, len,
                           $urandom_range(0, 4) != 0);
            end
         end
         calm = 1'b0;
      end
   endtask

   // A header with every length bit set. Only a few dozen payload bytes
   // follow, so the record stays open to the end of the run.
   task automatic test_long_length();
      set_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      send_record(64'h4059_0000_0000_0000, 16'h8001, 32'hFFFF_FFFF, 40, 1'b1);
      drain_block();
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random stalls, stretches without any when calm is set, and
   // one long hold-off on request, counted out here.
   // ------------------------------------------------------------------------
   initial begin : receiver
      int unsigned held;
      forever begin
         @(posedge clock);
         if (hold_requested) begin
            hold_requested = 1'b0;
            rsp_stall <= 1'b1;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(posedge clock);
               held++;
            end
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat (pause_length()) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result checker: every result transfer is matched against the oldest
   // prediction, field by field.
   // ------------------------------------------------------------------------
   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      result_type want;
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (predicted_rsp.size() == 0) begin
            $error("result transfer with no prediction waiting, kind 0x%0h", rsp_kind);
            fault_count++;
         end else begin
            want = predicted_rsp.pop_front();
            compare_field("kind", 64'(want.kind), 64'(rsp_kind));
            compare_field("payload_byte", 64'(want.payload_byte),
                          64'(rsp_payload_byte));
            compare_field("packet_id", 64'(want.packet_id), 64'(rsp_packet_id));
            compare_field("timestamp_bits", want.timestamp_bits, rsp_timestamp_bits);
            compare_field("payload_len", 64'(want.payload_len),
                          64'(rsp_payload_len));
            compare_field("last", 64'(want.last), 64'(rsp_last));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: ends the run if no transfer of any kind happens for too long.
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $error("no transfer for %0d cycles, %0d results still awaited",
             STALL_LIMIT, predicted_rsp.size());
      $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Test sequence. Reset is held high at the start, then lowered and never raised again.
   // ------------------------------------------------------------------------
   initial begin : test_sequence
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_first_records();
      test_order_switch_mid_field();
      test_receiver_hold_off();
      test_random_traffic();
      test_long_length();
      if (fault_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/lrd_pkg.sv
rtl/lrd_parse.sv
rtl/lrd_rsp_fifo.sv
rtl/log_record_deframer.sv
tb/sv/tb_log_record_deframer.sv
